@@ src/tsbm_pkg.sv @@
// Shared package for the three-stage biquad mixer: widths, register indexes,
// control-word types and the microcode program of the sequencer.
// No dependencies.
package tsbm_pkg;

  localparam int DEFAULT_SAMPLE_WIDTH = 16;
  localparam int DEFAULT_COEF_WIDTH   = 16;

  localparam int DELAY_W       = 32;
  localparam int CFG_W         = 48;
  localparam int VOL_W         = 7;
  localparam int CFG_IDX_W     = 3;
  localparam int NUM_SECT      = 3;
  localparam int SECT_W        = 2;
  localparam int NUM_COEF_REGS = 6;
  localparam int DIV_BASE      = 10;
  localparam int ROUND_BIAS    = 5;

  localparam logic [VOL_W-1:0] VOL_RESET = 7'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAINS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B0    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B1    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_B2    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VOL   = 3'd6;

  // program steps
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_IDLE       = 5'd0;
  localparam logic [STEP_W-1:0] STEP_SECT_FIRST = 5'd1;
  localparam logic [STEP_W-1:0] STEP_SECT_LAST  = 5'd24;
  localparam logic [STEP_W-1:0] STEP_VOL_MUL    = 5'd25;
  localparam logic [STEP_W-1:0] STEP_VOL_ACC    = 5'd26;
  localparam logic [STEP_W-1:0] STEP_CLAMP      = 5'd27;
  localparam logic [STEP_W-1:0] STEP_DIV_INIT   = 5'd28;
  localparam logic [STEP_W-1:0] STEP_DIV        = 5'd29;
  localparam logic [STEP_W-1:0] STEP_EMIT       = 5'd30;

  // phases within one section (eight steps each)
  localparam int PH_W = 3;
  localparam logic [PH_W-1:0] PH_GX  = 3'd0;
  localparam logic [PH_W-1:0] PH_A1  = 3'd1;
  localparam logic [PH_W-1:0] PH_A2  = 3'd2;
  localparam logic [PH_W-1:0] PH_B1  = 3'd3;
  localparam logic [PH_W-1:0] PH_B2  = 3'd4;
  localparam logic [PH_W-1:0] PH_B0  = 3'd5;
  localparam logic [PH_W-1:0] PH_ACC = 3'd6;
  localparam logic [PH_W-1:0] PH_Y   = 3'd7;

  typedef enum logic [2:0] {
    COEF_G, COEF_A1, COEF_A2, COEF_B0, COEF_B1, COEF_B2, COEF_VOL
  } coef_sel_e;

  typedef enum logic [1:0] {
    DATA_X, DATA_W1, DATA_W2, DATA_WN
  } data_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_CLAMP
  } acc_op_e;

  typedef enum logic [1:0] {
    RES_NONE, RES_W, RES_Y
  } res_op_e;

  typedef enum logic [1:0] {
    AUX_NONE, AUX_DIV_INIT, AUX_DIV_STEP, AUX_EMIT
  } aux_op_e;

  typedef enum logic [1:0] {
    SEQ_NEXT, SEQ_WAIT_IN, SEQ_WAIT_OUT
  } seq_op_e;

  typedef struct packed {
    coef_sel_e         coef;
    data_sel_e         data;
    acc_op_e           acc;
    res_op_e           res;
    aux_op_e           aux;
    seq_op_e           seq;
    logic [SECT_W-1:0] sect;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Microcode ROM. Per section: g*x, a1*w1, a2*w2 accumulate into w; b1*w1 and
  // b2*w2 are started while w is rescaled, then b0*w closes y.
  function automatic ucode_t ucode_word(input logic [STEP_W-1:0] step);
    ucode_t            w;
    logic [STEP_W-1:0] rel;
    w.coef   = COEF_G;
    w.data   = DATA_X;
    w.acc    = ACC_HOLD;
    w.res    = RES_NONE;
    w.aux    = AUX_NONE;
    w.seq    = SEQ_NEXT;
    w.sect   = '0;
    w.target = STEP_IDLE;
    rel      = step - STEP_SECT_FIRST;
    if (step >= STEP_SECT_FIRST && step <= STEP_SECT_LAST) begin
      w.sect = rel[PH_W +: SECT_W];
      unique case (rel[PH_W-1:0])
        PH_GX: begin
          w.coef = COEF_G;
          w.data = DATA_X;
        end
        PH_A1: begin
          w.coef = COEF_A1;
          w.data = DATA_W1;
          w.acc  = ACC_LOAD;
        end
        PH_A2: begin
          w.coef = COEF_A2;
          w.data = DATA_W2;
          w.acc  = ACC_SUB;
        end
        PH_B1: begin
          w.coef = COEF_B1;
          w.data = DATA_W1;
          w.acc  = ACC_SUB;
        end
        PH_B2: begin
          w.coef = COEF_B2;
          w.data = DATA_W2;
          w.acc  = ACC_LOAD;
          w.res  = RES_W;
        end
        PH_B0: begin
          w.coef = COEF_B0;
          w.data = DATA_WN;
          w.acc  = ACC_ADD;
        end
        PH_ACC: begin
          w.acc = ACC_ADD;
        end
        PH_Y: begin
          w.res = RES_Y;
        end
        default: ;
      endcase
    end else begin
      unique case (step)
        STEP_IDLE: begin
          w.seq = SEQ_WAIT_IN;
        end
        STEP_VOL_MUL: begin
          w.coef = COEF_VOL;
          w.data = DATA_X;
        end
        STEP_VOL_ACC: begin
          w.acc = ACC_LOAD;
        end
        STEP_CLAMP: begin
          w.acc = ACC_CLAMP;
        end
        STEP_DIV_INIT: begin
          w.aux = AUX_DIV_INIT;
        end
        STEP_DIV: begin
          w.aux = AUX_DIV_STEP;
        end
        STEP_EMIT: begin
          w.aux    = AUX_EMIT;
          w.seq    = SEQ_WAIT_OUT;
          w.target = STEP_IDLE;
        end
        default: ;
      endcase
    end
    return w;
  endfunction

endpackage

@@ src/tsbm_seq.sv @@
// Microcode sequencer: step counter and control ROM lookup.
// Depends on tsbm_pkg.
module tsbm_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             out_free_i,
  output tsbm_pkg::ucode_t ctrl_o,
  output logic             in_ready_o
);

  logic [tsbm_pkg::STEP_W-1:0] step_d, step_q;

  assign ctrl_o     = tsbm_pkg::ucode_word(step_q);
  assign in_ready_o = (ctrl_o.seq == tsbm_pkg::SEQ_WAIT_IN);

  always_comb begin
    step_d = step_q;
    unique case (ctrl_o.seq)
      tsbm_pkg::SEQ_NEXT: begin
        step_d = step_q + tsbm_pkg::STEP_W'(1);
      end
      tsbm_pkg::SEQ_WAIT_IN: begin
        if (in_valid_i) begin
          step_d = step_q + tsbm_pkg::STEP_W'(1);
        end
      end
      tsbm_pkg::SEQ_WAIT_OUT: begin
        if (out_free_i) begin
          step_d = ctrl_o.target;
        end
      end
      default: begin
        step_d = tsbm_pkg::STEP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= tsbm_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

@@ src/three_stage_biquad_mixer.sv @@
// Top level: three cascaded direct-form-II biquads, volume scaling and mix,
// run by a microcoded sequencer over one shared multiplier.
// Depends on tsbm_pkg and tsbm_seq.
//
// Usage: one beat on the s_axis side carries a sample to filter, a sample to
// mix in and, in tuser, a first-of-block flag that clears all section delays
// before filtering. One beat leaves on the m_axis side per input beat: the
// saturated result in tdata and a clip flag in tuser.
// Coefficients and volume are written over the cfg port while the block idles.
// Timing: a new item is accepted only at the idle step, once the last result
// has been written to the output register. Nineteen products go through the
// one multiplier, eight program steps per section and one for the volume; the
// divide by ten is a multiply by the reciprocal in a single step.
// Reset clears the delays, loads unity gains and b0, volume ten, and the
// program returns to its idle step with no result pending.
// A stalled receiver keeps its result in the output register; meanwhile the
// next item is accepted and worked, and the program holds at its last step
// until the register is free.
module three_stage_biquad_mixer #(
  parameter int SAMPLE_WIDTH = tsbm_pkg::DEFAULT_SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = tsbm_pkg::DEFAULT_COEF_WIDTH,
  localparam int IN_TDATA_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [IN_TDATA_W-1:0]          s_axis_tdata,  // sample_in, mix_sample
  input  logic                           s_axis_tuser,  // first_of_block
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [OUT_TDATA_W-1:0]         m_axis_tdata,  // sample_out
  output logic                           m_axis_tuser,  // clipped
  input  logic                           cfg_we_i,
  input  logic [tsbm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tsbm_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int DW     = tsbm_pkg::DELAY_W;
  localparam int FB     = COEF_WIDTH - 3;
  localparam int PROD_W = DW + COEF_WIDTH;
  localparam int ACC_W  = PROD_W + 2;
  localparam int RS_W   = ACC_W + 1;
  localparam int PAD_W  = (3 * COEF_WIDTH > tsbm_pkg::CFG_W) ? 3 * COEF_WIDTH
                                                               : tsbm_pkg::CFG_W;
  localparam int DVD_W  = SAMPLE_WIDTH + 5;
  localparam int RCP_SH = DVD_W + 3;
  localparam int RCP_W  = DVD_W + 1;
  localparam int RPR_W  = DVD_W + RCP_W;
  localparam int QU_W   = SAMPLE_WIDTH + 2;
  localparam int Q_W    = SAMPLE_WIDTH + 3;

  localparam longint FIN_LIM = longint'(tsbm_pkg::DIV_BASE) << SAMPLE_WIDTH;
  localparam logic signed [ACC_W-1:0] FIN_HI  = ACC_W'(FIN_LIM - tsbm_pkg::ROUND_BIAS);
  localparam logic signed [ACC_W-1:0] FIN_LO  = ACC_W'(-FIN_LIM - tsbm_pkg::ROUND_BIAS);
  localparam logic signed [ACC_W-1:0] FIN_OFS = ACC_W'(FIN_LIM + tsbm_pkg::ROUND_BIAS);

  localparam logic signed [RS_W-1:0] RS_HALF = RS_W'(longint'(1) << (FB - 1));
  localparam logic signed [RS_W-1:0] RS_MAX  = RS_W'(64'sd2147483647);
  localparam logic signed [RS_W-1:0] RS_MIN  = RS_W'(-64'sd2147483648);

  localparam logic signed [Q_W-1:0] Q_BIAS = Q_W'(longint'(1) << SAMPLE_WIDTH);
  localparam logic signed [Q_W-1:0] S_MAX  =
      Q_W'((longint'(1) << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [Q_W-1:0] S_MIN  = Q_W'(-(longint'(1) << (SAMPLE_WIDTH - 1)));

  // reciprocal of ten rounded up; exact for every dividend below 2**DVD_W
  localparam logic [RCP_W-1:0] RCP =
      RCP_W'(((longint'(1) << RCP_SH) + longint'(tsbm_pkg::DIV_BASE) - 1)
             / longint'(tsbm_pkg::DIV_BASE));

  function automatic logic [tsbm_pkg::CFG_W-1:0] unity_lanes();
    logic [tsbm_pkg::CFG_W-1:0] v;
    v = '0;
    for (int s = 0; s < tsbm_pkg::NUM_SECT; s++) begin
      if (s * COEF_WIDTH + FB < tsbm_pkg::CFG_W) begin
        v[s * COEF_WIDTH + FB] = 1'b1;
      end
    end
    return v;
  endfunction

  localparam logic [tsbm_pkg::CFG_W-1:0] UNITY = unity_lanes();

  tsbm_pkg::ucode_t ctrl;
  logic             in_ready, in_fire, out_free, emit;

  logic [tsbm_pkg::CFG_W-1:0] cfg_q [tsbm_pkg::NUM_COEF_REGS];
  logic [tsbm_pkg::VOL_W-1:0] vol_q;

  logic signed [DW-1:0] w1_q [tsbm_pkg::NUM_SECT];
  logic signed [DW-1:0] w2_q [tsbm_pkg::NUM_SECT];
  logic signed [DW-1:0] wn_q, x_q;

  logic signed [SAMPLE_WIDTH-1:0] sample_s, mix_s, mix_q;

  logic [tsbm_pkg::CFG_W-1:0]   coef_reg;
  logic [PAD_W-1:0]             coef_pad;
  logic signed [DW-1:0]         opa;
  logic signed [COEF_WIDTH-1:0] opb;
  logic signed [PROD_W-1:0]     prod_d, prod_q;
  logic signed [ACC_W-1:0]      prod_ext, acc_d, acc_q;

  logic signed [RS_W-1:0] rs_sum, rs_shift;
  logic signed [DW-1:0]   rs_val;
  logic                   rs_sat;

  logic [DVD_W-1:0] dvd_d, dvd_q;
  logic [RPR_W-1:0] rcp_prod;
  logic [QU_W-1:0]  quot_d, quot_q;

  logic signed [Q_W-1:0]   q_s, sum_s;
  logic [SAMPLE_WIDTH-1:0] sum_sat;
  logic                    sum_clip;

  logic                    flag_q;
  logic                    out_valid_q, out_clip_q;
  logic [SAMPLE_WIDTH-1:0] out_data_q;

  tsbm_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .out_free_i(out_free),
    .ctrl_o    (ctrl),
    .in_ready_o(in_ready)
  );

  assign s_axis_tready = in_ready;
  assign in_fire       = s_axis_tvalid & in_ready;
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign emit          = (ctrl.aux == tsbm_pkg::AUX_EMIT) & out_free;

  assign sample_s = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign mix_s    = s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];

  // operand selection for the shared multiplier
  always_comb begin
    coef_reg = cfg_q[tsbm_pkg::REG_GAINS];
    unique case (ctrl.coef)
      tsbm_pkg::COEF_G:  coef_reg = cfg_q[tsbm_pkg::REG_GAINS];
      tsbm_pkg::COEF_A1: coef_reg = cfg_q[tsbm_pkg::REG_A1];
      tsbm_pkg::COEF_A2: coef_reg = cfg_q[tsbm_pkg::REG_A2];
      tsbm_pkg::COEF_B0: coef_reg = cfg_q[tsbm_pkg::REG_B0];
      tsbm_pkg::COEF_B1: coef_reg = cfg_q[tsbm_pkg::REG_B1];
      tsbm_pkg::COEF_B2: coef_reg = cfg_q[tsbm_pkg::REG_B2];
      default:           coef_reg = cfg_q[tsbm_pkg::REG_GAINS];
    endcase
    coef_pad = PAD_W'(coef_reg);
    if (ctrl.coef == tsbm_pkg::COEF_VOL) begin
      opb = $signed(COEF_WIDTH'(vol_q));
    end else begin
      opb = $signed(coef_pad[ctrl.sect * COEF_WIDTH +: COEF_WIDTH]);
    end
    unique case (ctrl.data)
      tsbm_pkg::DATA_X:  opa = x_q;
      tsbm_pkg::DATA_W1: opa = w1_q[ctrl.sect];
      tsbm_pkg::DATA_W2: opa = w2_q[ctrl.sect];
      tsbm_pkg::DATA_WN: opa = wn_q;
      default:           opa = x_q;
    endcase
  end

  assign prod_d   = opa * opb;
  assign prod_ext = ACC_W'(prod_q);

  always_comb begin
    acc_d = acc_q;
    case (ctrl.acc)
      tsbm_pkg::ACC_LOAD: acc_d = prod_ext;
      tsbm_pkg::ACC_ADD:  acc_d = acc_q + prod_ext;
      tsbm_pkg::ACC_SUB:  acc_d = acc_q - prod_ext;
      tsbm_pkg::ACC_CLAMP: begin
        if (acc_q > FIN_HI) begin
          acc_d = FIN_HI;
        end else if (acc_q < FIN_LO) begin
          acc_d = FIN_LO;
        end
      end
      default: acc_d = acc_q;
    endcase
  end

  // round half up, drop FB fraction bits, saturate to the delay width
  always_comb begin
    rs_sum   = RS_W'(acc_q) + RS_HALF;
    rs_shift = rs_sum >>> FB;
    rs_sat   = (rs_shift > RS_MAX) || (rs_shift < RS_MIN);
    if (rs_shift > RS_MAX) begin
      rs_val = RS_MAX[DW-1:0];
    end else if (rs_shift < RS_MIN) begin
      rs_val = RS_MIN[DW-1:0];
    end else begin
      rs_val = rs_shift[DW-1:0];
    end
  end

  // floor divide by ten: multiply by the reciprocal and keep the high bits
  always_comb begin
    rcp_prod = RPR_W'(dvd_q) * RPR_W'(RCP);
    dvd_d    = dvd_q;
    quot_d   = quot_q;
    if (ctrl.aux == tsbm_pkg::AUX_DIV_INIT) begin
      dvd_d = DVD_W'(acc_q + FIN_OFS);
    end else if (ctrl.aux == tsbm_pkg::AUX_DIV_STEP) begin
      quot_d = rcp_prod[RCP_SH +: QU_W];
    end
  end

  // quotient carries a bias of one full scale; remove it, add mix, saturate
  always_comb begin
    q_s      = $signed(Q_W'(quot_q)) - Q_BIAS;
    sum_s    = q_s + Q_W'(mix_q);
    sum_clip = (sum_s > S_MAX) || (sum_s < S_MIN);
    if (sum_s > S_MAX) begin
      sum_sat = S_MAX[SAMPLE_WIDTH-1:0];
    end else if (sum_s < S_MIN) begin
      sum_sat = S_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      sum_sat = sum_s[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    dvd_q  <= dvd_d;
    quot_q <= quot_d;
    if (in_fire) begin
      x_q    <= DW'(sample_s);
      mix_q  <= mix_s;
      flag_q <= 1'b0;
    end else begin
      if (ctrl.res == tsbm_pkg::RES_Y) begin
        x_q <= rs_val;
      end
      if (ctrl.res != tsbm_pkg::RES_NONE && rs_sat) begin
        flag_q <= 1'b1;
      end
    end
    if (ctrl.res == tsbm_pkg::RES_W) begin
      wn_q <= rs_val;
    end
    if (emit) begin
      out_data_q <= sum_sat;
      out_clip_q <= flag_q | sum_clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tsbm_pkg::NUM_COEF_REGS; i++) begin
        cfg_q[i] <= '0;
      end
      cfg_q[tsbm_pkg::REG_GAINS] <= UNITY;
      cfg_q[tsbm_pkg::REG_B0]    <= UNITY;
      vol_q                      <= tsbm_pkg::VOL_RESET;
      for (int s = 0; s < tsbm_pkg::NUM_SECT; s++) begin
        w1_q[s] <= '0;
        w2_q[s] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == tsbm_pkg::REG_VOL) begin
          vol_q <= cfg_data_i[tsbm_pkg::VOL_W-1:0];
        end else if (cfg_idx_i < tsbm_pkg::REG_VOL) begin
          cfg_q[cfg_idx_i] <= cfg_data_i;
        end
      end
      if (in_fire && s_axis_tuser) begin
        for (int s = 0; s < tsbm_pkg::NUM_SECT; s++) begin
          w1_q[s] <= '0;
          w2_q[s] <= '0;
        end
      end else if (ctrl.res == tsbm_pkg::RES_Y) begin
        w2_q[ctrl.sect] <= w1_q[ctrl.sect];
        w1_q[ctrl.sect] <= wn_q;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_data_q);
  assign m_axis_tuser  = out_clip_q;

endmodule
